/* hdl/lkv_pkg.sv */
package lkv_pkg;

    // Default sizes of the store.
    localparam int LKV_MAX_ENTRIES = 16;
    localparam int LKV_KEY_BITS    = 32;
    localparam int LKV_VALUE_BITS  = 32;

    // Capacity register.
    localparam int             CFG_W         = 5;
    localparam logic [CFG_W-1:0] CFG_RESET   = 5'd16;

    // Field widths of the beats on the two channels.
    localparam int FIELD_W = 32;

    // Operation codes carried in the kind field.
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // Data returned by a get that misses.
    localparam logic [FIELD_W-1:0] MISS_DATA = '1;

    typedef struct packed {
        logic                      kind;
        logic signed [FIELD_W-1:0] lookup_key;
        logic signed [FIELD_W-1:0] write_data;
    } in_beat_t;

    typedef struct packed {
        logic                      hit;
        logic signed [FIELD_W-1:0] read_data;
    } out_beat_t;

    // Recency update issued at the end of an operation.
    typedef enum logic [1:0] {
        RK_NONE   = 2'd0,
        RK_TOUCH  = 2'd1,
        RK_INSERT = 2'd2
    } rank_op_t;

    typedef struct packed {
        rank_op_t op;
        logic     evict;
    } rank_cmd_t;

    // What the scan found.
    typedef struct packed {
        logic hit;
        logic free;
    } match_flags_t;

endpackage

/* hdl/lkv_store.sv */
module lkv_store
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = LKV_MAX_ENTRIES,
    parameter int KEY_BITS   = LKV_KEY_BITS,
    parameter int VALUE_BITS = LKV_VALUE_BITS,
    localparam int IW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [IW-1:0]         wr_idx,
    input  logic [KEY_BITS-1:0]   wr_key,
    input  logic [VALUE_BITS-1:0] wr_val,
    input  logic [IW-1:0]         rd_idx,
    output logic [KEY_BITS-1:0]   rd_key,
    output logic [VALUE_BITS-1:0] rd_val
);

    // Key and value arrays share one write port and one registered read port.
    logic [KEY_BITS-1:0]   key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] val_mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_idx] <= wr_key;
            val_mem[wr_idx] <= wr_val;
        end
        rd_key <= key_mem[rd_idx];
        rd_val <= val_mem[rd_idx];
    end

endmodule

/* hdl/lkv_match.sv */
module lkv_match
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = LKV_MAX_ENTRIES,
    parameter int KEY_BITS   = LKV_KEY_BITS,
    parameter int VALUE_BITS = LKV_VALUE_BITS,
    localparam int IW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear,
    input  logic                  en,
    input  logic [IW-1:0]         idx,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [KEY_BITS-1:0]   rd_key,
    input  logic [VALUE_BITS-1:0] rd_val,
    input  logic                  ent_valid,
    input  logic                  ent_oldest,
    output match_flags_t          flags,
    output logic [IW-1:0]         hit_idx,
    output logic [VALUE_BITS-1:0] hit_val,
    output logic [IW-1:0]         free_idx,
    output logic [IW-1:0]         vict_idx
);

    match_flags_t          flags_reg, flags_next;
    logic [IW-1:0]         hit_idx_reg, hit_idx_next;
    logic [VALUE_BITS-1:0] hit_val_reg, hit_val_next;
    logic [IW-1:0]         free_idx_reg, free_idx_next;
    logic [IW-1:0]         vict_idx_reg, vict_idx_next;

    // One entry is examined per cycle while en is high: key compare, oldest check, free check.
    always_comb begin
        flags_next    = flags_reg;
        hit_idx_next  = hit_idx_reg;
        hit_val_next  = hit_val_reg;
        free_idx_next = free_idx_reg;
        vict_idx_next = vict_idx_reg;
        if (clear) begin
            flags_next = '0;
        end else if (en) begin
            if (ent_valid && (rd_key == key) && !flags_reg.hit) begin
                flags_next.hit = 1'b1;
                hit_idx_next   = idx;
                hit_val_next   = rd_val;
            end
            if (ent_oldest) begin
                vict_idx_next = idx;
            end
            if (!ent_valid && !flags_reg.free) begin
                flags_next.free = 1'b1;
                free_idx_next   = idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_idx_reg  <= hit_idx_next;
        hit_val_reg  <= hit_val_next;
        free_idx_reg <= free_idx_next;
        vict_idx_reg <= vict_idx_next;
    end

    assign flags    = flags_reg;
    assign hit_idx  = hit_idx_reg;
    assign hit_val  = hit_val_reg;
    assign free_idx = free_idx_reg;
    assign vict_idx = vict_idx_reg;

endmodule

/* hdl/lkv_rank.sv */
module lkv_rank
    import lkv_pkg::*;
#(
    parameter int ENTRIES = LKV_MAX_ENTRIES,
    localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int OW     = $clog2(ENTRIES + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rank_cmd_t          cmd,
    input  logic [IW-1:0]      idx,
    input  logic [IW-1:0]      vict_idx,
    output logic [ENTRIES-1:0] valid_vec,
    output logic [ENTRIES-1:0] oldest_vec,
    output logic [OW-1:0]      occ
);

    // Ranks of valid entries always form 0 .. occ-1, with 0 the most recent.
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IW-1:0]      rank_reg [ENTRIES];
    logic [IW-1:0]      rank_next [ENTRIES];
    logic [OW-1:0]      occ_reg, occ_next;
    logic [IW-1:0]      ref_rank;
    logic [IW-1:0]      last_rank;

    assign ref_rank  = rank_reg[idx];
    assign last_rank = IW'(occ_reg - OW'(1));

    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        unique case (cmd.op)
            RK_TOUCH: begin
                for (int j = 0; j < ENTRIES; j++) begin
                    if (valid_reg[j] && (rank_reg[j] < ref_rank)) begin
                        rank_next[j] = rank_reg[j] + IW'(1);
                    end
                end
                rank_next[idx] = '0;
            end
            RK_INSERT: begin
                for (int j = 0; j < ENTRIES; j++) begin
                    if (cmd.evict && (IW'(j) == vict_idx)) begin
                        valid_next[j] = 1'b0;
                        rank_next[j]  = '0;
                    end else if (valid_reg[j]) begin
                        rank_next[j] = rank_reg[j] + IW'(1);
                    end
                end
                valid_next[idx] = 1'b1;
                rank_next[idx]  = '0;
                if (!cmd.evict) begin
                    occ_next = occ_reg + OW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int j = 0; j < ENTRIES; j++) begin
                rank_reg[j] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            rank_reg  <= rank_next;
        end
    end

    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            oldest_vec[j] = valid_reg[j] && (rank_reg[j] == last_rank);
        end
    end

    assign valid_vec = valid_reg;
    assign occ       = occ_reg;

    a_occ_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy count disagrees with valid marks");

    a_insert_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == RK_INSERT |=> valid_reg[$past(idx)] && (rank_reg[$past(idx)] == '0))
        else $error("inserted entry is not valid and most recent");

    a_single_oldest: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(oldest_vec))
        else $error("more than one entry marked least recent");

endmodule

/* hdl/lru_key_value_cache.sv */
// Fully associative key-value cache with least-recently-used replacement.
//
// Input channel (s_valid / s_ready / s_in): one beat is a get or a put with a
// key and, for a put, a value. Result channel (m_valid / m_ready / m_out):
// exactly one beat per input beat, in order, carrying the hit flag and the
// read data (the stored value on a get hit, all ones on a get miss, zero for
// every put).
// Each operation scans the key store one entry per cycle through a single
// comparator, then passes a last compare step and a commit step; the result
// is registered at the commit, and the next beat is taken only after it.
// The block accepts a new beat only between operations, and a new beat may be
// accepted while the previous result still waits in the output register.
// If the receiver stalls, the finished operation holds in its commit step
// until the output register frees up, and nothing is updated before then.
// The capacity register (cfg_wr_en / cfg_wr_data) limits how many entries are
// held before eviction starts; zero acts as one and values above MAX_ENTRIES
// act as MAX_ENTRIES. Write it only while no operation is in flight.
// Reset empties the cache, sets the capacity to 16 and drops any pending
// result.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int MAX_ENTRIES = LKV_MAX_ENTRIES,
    parameter int KEY_BITS    = LKV_KEY_BITS,
    parameter int VALUE_BITS  = LKV_VALUE_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_beat_t         s_in,
    output logic             m_valid,
    input  logic             m_ready,
    output out_beat_t        m_out,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (OW > CFG_W) ? OW : CFG_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [IW-1:0]         scan_idx_reg, scan_idx_next;
    logic                  cmp_en_reg;
    logic [IW-1:0]         cmp_idx_reg;
    logic [CFG_W-1:0]      cap_cfg_reg;

    // Operation being worked on.
    logic                  kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] data_reg;

    logic                  m_valid_reg, m_valid_next;
    out_beat_t             m_out_reg, m_out_next;

    logic                  accept;
    logic                  go;

    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    match_flags_t          flags;
    logic [IW-1:0]         hit_idx;
    logic [VALUE_BITS-1:0] hit_val;
    logic [IW-1:0]         free_idx;
    logic [IW-1:0]         vict_idx;

    logic [MAX_ENTRIES-1:0] valid_vec;
    logic [MAX_ENTRIES-1:0] oldest_vec;
    logic [OW-1:0]          occ;

    logic [CW-1:0]         cap;
    logic                  evict;
    logic [IW-1:0]         slot;
    rank_cmd_t             rank_cmd;
    logic [IW-1:0]         rank_idx;
    logic                  wr_en;
    logic [IW-1:0]         wr_idx;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign go = (state_reg == ST_COMMIT) && (!m_valid_reg || m_ready);

    // Sequencer: issue one read per cycle, compare in the next cycle.
    always_comb begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                scan_idx_next = '0;
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg == IW'(MAX_ENTRIES - 1)) begin
                    state_next = ST_LAST;
                end else begin
                    scan_idx_next = scan_idx_reg + IW'(1);
                end
            end
            ST_LAST: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            cmp_en_reg   <= 1'b0;
            cap_cfg_reg  <= CFG_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            cmp_en_reg   <= (state_reg == ST_SCAN);
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                cap_cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= scan_idx_reg;
        m_out_reg   <= m_out_next;
        if (accept) begin
            kind_reg <= s_in.kind;
            key_reg  <= KEY_BITS'($unsigned(s_in.lookup_key));
            data_reg <= VALUE_BITS'($unsigned(s_in.write_data));
        end
    end

    // Effective capacity, clamped to 1 .. MAX_ENTRIES.
    always_comb begin
        if (cap_cfg_reg == '0) begin
            cap = CW'(1);
        end else if (CW'(cap_cfg_reg) > CW'(MAX_ENTRIES)) begin
            cap = CW'(MAX_ENTRIES);
        end else begin
            cap = CW'(cap_cfg_reg);
        end
    end

    // A full store gives up its least recent entry. The new key goes to the
    // lowest free slot, which may be the one just vacated.
    assign evict = (CW'(occ) >= cap);

    always_comb begin
        if (evict && !(flags.free && (free_idx < vict_idx))) begin
            slot = vict_idx;
        end else begin
            slot = free_idx;
        end
    end

    // Commit: store write, recency update and result, all at the same edge.
    always_comb begin
        rank_cmd.op    = RK_NONE;
        rank_cmd.evict = 1'b0;
        rank_idx       = slot;
        wr_en          = 1'b0;
        wr_idx         = slot;
        if (go) begin
            if (flags.hit) begin
                rank_cmd.op = RK_TOUCH;
                rank_idx    = hit_idx;
                wr_idx      = hit_idx;
                wr_en       = (kind_reg == KIND_PUT);
            end else if (kind_reg == KIND_PUT) begin
                rank_cmd.op    = RK_INSERT;
                rank_cmd.evict = evict;
                wr_en          = 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_out_next   = m_out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (go) begin
            m_valid_next   = 1'b1;
            m_out_next.hit = flags.hit;
            if (kind_reg == KIND_PUT) begin
                m_out_next.read_data = '0;
            end else if (flags.hit) begin
                m_out_next.read_data = $signed(FIELD_W'(hit_val));
            end else begin
                m_out_next.read_data = $signed(MISS_DATA);
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out   = m_out_reg;

    lkv_store #(
        .ENTRIES    (MAX_ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_idx (wr_idx),
        .wr_key (key_reg),
        .wr_val (data_reg),
        .rd_idx (scan_idx_reg),
        .rd_key (rd_key),
        .rd_val (rd_val)
    );

    lkv_match #(
        .ENTRIES    (MAX_ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_match (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (accept),
        .en         (cmp_en_reg),
        .idx        (cmp_idx_reg),
        .key        (key_reg),
        .rd_key     (rd_key),
        .rd_val     (rd_val),
        .ent_valid  (valid_vec[cmp_idx_reg]),
        .ent_oldest (oldest_vec[cmp_idx_reg]),
        .flags      (flags),
        .hit_idx    (hit_idx),
        .hit_val    (hit_val),
        .free_idx   (free_idx),
        .vict_idx   (vict_idx)
    );

    lkv_rank #(
        .ENTRIES (MAX_ENTRIES)
    ) u_rank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (rank_cmd),
        .idx        (rank_idx),
        .vict_idx   (vict_idx),
        .valid_vec  (valid_vec),
        .oldest_vec (oldest_vec),
        .occ        (occ)
    );

    a_result_after_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_COMMIT))
        else $error("result appeared without a commit");

    a_commit_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        go |=> m_valid_reg)
        else $error("commit did not load the output register");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        go && !flags.hit && (kind_reg == KIND_PUT) && !evict
        |=> occ == $past(occ) + OW'(1))
        else $error("insert into free space did not grow occupancy");

    a_evict_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        go && !flags.hit && (kind_reg == KIND_PUT) && evict |=> $stable(occ))
        else $error("evicting insert changed occupancy");

endmodule
